// ===== rtl/length_prefixed_message_ring_push_defines.svh =====
// Assertion macros shared by the message ring push logic.
`ifndef LENGTH_PREFIXED_MESSAGE_RING_PUSH_DEFINES_SVH
`define LENGTH_PREFIXED_MESSAGE_RING_PUSH_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define LPMR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define LPMR_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lpmr_pkg.sv =====
// Types, codes and constants of the message ring push block.
`timescale 1ns / 1ps
`default_nettype none

package lpmr_pkg;

  localparam int unsigned RING_BYTES_DEF   = 4096;
  localparam int unsigned MAX_MESSAGES_DEF = 256;
  localparam int unsigned HDR_BYTES        = 4;

  localparam int unsigned LEN_W      = 16;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned MAX_LEN_W  = 12;
  localparam int unsigned LIMIT_W    = 9;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned HELD_W     = 9;
  localparam int unsigned USED_OUT_W = 13;
  localparam int unsigned DROP_W     = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RST = 12'd1024;
  localparam logic [LIMIT_W-1:0]   LIMIT_RST   = 9'd256;
  localparam logic                 DROP_RST    = 1'b0;

  localparam logic OP_HEADER = 1'b0;
  localparam logic OP_DATA   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MSG_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DROP_MODE = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    STAT_ACCEPTED  = 3'd0,
    STAT_EMPTY     = 3'd1,
    STAT_OVER_MAX  = 3'd2,
    STAT_OVER_RING = 3'd3,
    STAT_NO_ROOM   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EV_TEST,
    ST_EV_READ,
    ST_EV_APPLY,
    ST_DECIDE,
    ST_WR_HDR,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic              op;
    logic [LEN_W-1:0]  message_length;
    logic [BYTE_W-1:0] payload_byte;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [HELD_W-1:0]     evicted_now;
    logic [DROP_W-1:0]     dropped_total;
    logic [HELD_W-1:0]     messages_held;
    logic [USED_OUT_W-1:0] bytes_used;
  } out_word_t;

endpackage

`default_nettype wire

// ===== rtl/length_prefixed_message_ring_push.sv =====
// Top level of the length-prefixed message ring, push side.
`timescale 1ns / 1ps
`default_nettype none

// Push side of a byte ring that stores messages as a 4-byte little-endian
// length header followed by the payload. A header word asks to admit a message
// and always yields exactly one result word. A data word fills the payload of
// the message admitted last and yields nothing. It is dropped when no payload
// is pending. The input closes while a header is handled. An admitted
// header passes the check, the decision and the four header byte writes,
// then loads its result into the output register. The size checks reject a
// header at the check, and a header that finds no room is rejected at the
// decision. In drop-oldest mode a header that passes the size checks first
// tests for eviction; each message it evicts adds a test, the header reads
// and an apply step. Each eviction reads the stored 4-byte header through
// the single read port of the ring memory, one byte per cycle, and then
// retires the message. A stored header that cannot be used ends the walk
// once read. A result that finds the output register still occupied waits
// until the register is free. The input opens again with the edge that loads
// the result. The result sits in an output register, so data words keep
// flowing while it waits to be taken. The ring memory needs no clearing
// pass after reset, because a header is always written before it can be read.
module length_prefixed_message_ring_push import lpmr_pkg::*; #(
  parameter int unsigned RING_BYTES   = RING_BYTES_DEF,
  parameter int unsigned MAX_MESSAGES = MAX_MESSAGES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire in_word_t              in_word_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_word_t                  out_word_o
);

`include "length_prefixed_message_ring_push_defines.svh"

  // Pointer, byte count and message count widths follow from the ring size
  // and the message capacity.
  localparam int unsigned PTR_W  = $clog2(RING_BYTES);
  localparam int unsigned SUM_W  = PTR_W + 1;
  localparam int unsigned USED_W = $clog2(RING_BYTES + 1);
  localparam int unsigned CNT_W  = $clog2(MAX_MESSAGES + 1);
  localparam int unsigned NEED_W = LEN_W + 1;

  // Advance a ring pointer by n, where n never exceeds the ring size.
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] p,
                                                 input logic [SUM_W-1:0] n);
    logic [SUM_W-1:0] s;
    s = {1'b0, p} + n;
    if (s >= SUM_W'(RING_BYTES)) begin
      s = s - SUM_W'(RING_BYTES);
    end
    return s[PTR_W-1:0];
  endfunction

  // Configuration registers.
  logic [MAX_LEN_W-1:0] cfg_max_q;
  logic [LIMIT_W-1:0]   cfg_limit_q;
  logic                 cfg_drop_q;

  // Ring bookkeeping and sequencer state.
  state_e               state_q, state_d;
  logic [PTR_W-1:0]     head_q, head_d;
  logic [PTR_W-1:0]     tail_q, tail_d;
  logic [PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [USED_W-1:0]    used_q, used_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [CNT_W-1:0]     evict_q, evict_d;
  logic [DROP_W-1:0]    drop_q, drop_d;
  logic [MAX_LEN_W-1:0] rem_q, rem_d;
  logic [LEN_W-1:0]     len_q, len_d;
  logic [31:0]          hdr_len_q, hdr_len_d;
  logic [2:0]           idx_q, idx_d;
  status_e              status_q, status_d;
  logic                 out_valid_q, out_valid_d;
  out_word_t            out_q, out_d;

  // Ring memory ports.
  logic              mem_we;
  logic [PTR_W-1:0]  mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [BYTE_W-1:0] mem_rdata;

  // Admission conditions for the header being handled.
  logic              in_acc;
  logic              out_free;
  logic              drop_inc;
  logic [NEED_W-1:0] need_w;
  logic [31:0]       lim_w;
  logic              full_w;
  logic              can_evict_w;
  logic              hdr_bad_w;
  logic [USED_W-1:0] need_ev_w;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign need_w = NEED_W'(len_q) + NEED_W'(HDR_BYTES);

  // The effective message limit is the smaller of the register and the
  // capacity the counters were built for.
  assign lim_w = (32'(cfg_limit_q) < 32'(MAX_MESSAGES)) ? 32'(cfg_limit_q)
                                                        : 32'(MAX_MESSAGES);

  // The ring cannot take the message as it stands: too many messages held,
  // or too few free bytes for header plus payload.
  assign full_w = (32'(cnt_q) >= lim_w) ||
                  ((32'(RING_BYTES) - 32'(used_q)) < 32'(need_w));

  // Eviction is only attempted when the oldest header can be read at all.
  assign can_evict_w = full_w && (cnt_q != '0) && (used_q >= USED_W'(HDR_BYTES));

  // A stored header that claims more bytes than are in use ends the
  // eviction walk.
  assign hdr_bad_w = hdr_len_q > (32'(used_q) - 32'(HDR_BYTES));
  assign need_ev_w = USED_W'(hdr_len_q) + USED_W'(HDR_BYTES);

  lpmr_ring_mem #(
    .DEPTH  (RING_BYTES),
    .ADDR_W (PTR_W)
  ) u_ring_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wdata),
    .rd_en_i   (mem_re),
    .rd_addr_i (rd_ptr_q),
    .rd_data_o (mem_rdata)
  );

  // Configuration writes. Indexes past the register list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_max_q   <= MAX_LEN_RST;
      cfg_limit_q <= LIMIT_RST;
      cfg_drop_q  <= DROP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_BYTES: cfg_max_q   <= cfg_wdata_i[MAX_LEN_W-1:0];
        CFG_MSG_LIMIT: cfg_limit_q <= cfg_wdata_i[LIMIT_W-1:0];
        CFG_DROP_MODE: cfg_drop_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Sequencer next state. A header walks check, optional eviction, the
  // admission decision, the header write and finally the result hand-off.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_word_i.op == OP_HEADER)) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if ((len_q == '0) || (len_q > LEN_W'(cfg_max_q)) ||
            (32'(need_w) > 32'(RING_BYTES))) begin
          state_d = ST_RESULT;
        end else if (cfg_drop_q) begin
          state_d = ST_EV_TEST;
        end else begin
          state_d = ST_DECIDE;
        end
      end
      ST_EV_TEST: begin
        state_d = can_evict_w ? ST_EV_READ : ST_DECIDE;
      end
      ST_EV_READ: begin
        if (idx_q == 3'd4) begin
          state_d = ST_EV_APPLY;
        end
      end
      ST_EV_APPLY: begin
        state_d = hdr_bad_w ? ST_DECIDE : ST_EV_TEST;
      end
      ST_DECIDE: begin
        state_d = full_w ? ST_RESULT : ST_WR_HDR;
      end
      ST_WR_HDR: begin
        if (idx_q == 3'd3) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control. Reads happen only while evicting and writes
  // only while idle or writing a header, so a read never meets a write of the
  // same cycle, and the memory's write-then-read ordering across cycles is
  // all that is needed.
  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    rd_ptr_d    = rd_ptr_q;
    used_d      = used_q;
    cnt_d       = cnt_q;
    evict_d     = evict_q;
    rem_d       = rem_q;
    len_d       = len_q;
    hdr_len_d   = hdr_len_q;
    idx_d       = idx_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    drop_inc    = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = tail_q;
    mem_wdata   = in_word_i.payload_byte;
    mem_re      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_word_i.op == OP_DATA) begin
            // A data word lands only while a payload is still pending.
            if (rem_q != '0) begin
              mem_we = 1'b1;
              tail_d = wrap_add(tail_q, SUM_W'(1));
              rem_d  = rem_q - 1'b1;
            end
          end else begin
            // A new header closes any unfinished payload: its reserved bytes
            // are skipped and keep whatever they held.
            len_d   = in_word_i.message_length;
            evict_d = '0;
            if (rem_q != '0) begin
              tail_d = wrap_add(tail_q, SUM_W'(rem_q));
              rem_d  = '0;
            end
          end
        end
      end
      ST_CHECK: begin
        if (len_q == '0) begin
          status_d = STAT_EMPTY;
        end else if (len_q > LEN_W'(cfg_max_q)) begin
          status_d = STAT_OVER_MAX;
          drop_inc = 1'b1;
        end else if (32'(need_w) > 32'(RING_BYTES)) begin
          status_d = STAT_OVER_RING;
          drop_inc = 1'b1;
        end
      end
      ST_EV_TEST: begin
        rd_ptr_d = head_q;
        idx_d    = '0;
      end
      ST_EV_READ: begin
        // Issue the four header byte reads; each byte returns through the registered
        // read port and shifts in from the top, so the first byte ends at the bottom.
        if (idx_q != 3'd4) begin
          mem_re   = 1'b1;
          rd_ptr_d = wrap_add(rd_ptr_q, SUM_W'(1));
        end
        if (idx_q != 3'd0) begin
          hdr_len_d = {mem_rdata, hdr_len_q[31:BYTE_W]};
        end
        idx_d = idx_q + 1'b1;
      end
      ST_EV_APPLY: begin
        if (!hdr_bad_w) begin
          head_d   = wrap_add(head_q, SUM_W'(need_ev_w));
          used_d   = used_q - need_ev_w;
          cnt_d    = cnt_q - 1'b1;
          evict_d  = evict_q + 1'b1;
          drop_inc = 1'b1;
        end
      end
      ST_DECIDE: begin
        idx_d = '0;
        if (full_w) begin
          status_d = STAT_NO_ROOM;
          drop_inc = 1'b1;
        end
      end
      ST_WR_HDR: begin
        mem_we = 1'b1;
        unique case (idx_q)
          3'd0:    mem_wdata = len_q[BYTE_W-1:0];
          3'd1:    mem_wdata = len_q[LEN_W-1:BYTE_W];
          default: mem_wdata = '0;
        endcase
        tail_d = wrap_add(tail_q, SUM_W'(1));
        idx_d  = idx_q + 1'b1;
        if (idx_q == 3'd3) begin
          used_d   = used_q + USED_W'(need_w);
          cnt_d    = cnt_q + 1'b1;
          rem_d    = len_q[MAX_LEN_W-1:0];
          status_d = STAT_ACCEPTED;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          out_valid_d             = 1'b1;
          out_d.status            = status_q;
          out_d.evicted_now       = HELD_W'(evict_q);
          out_d.dropped_total     = drop_q;
          out_d.messages_held     = HELD_W'(cnt_q);
          out_d.bytes_used        = USED_OUT_W'(used_q);
        end
      end
      default: ;
    endcase

    // The drop count sticks at its maximum.
    drop_d = (drop_inc && (drop_q != '1)) ? drop_q + 1'b1 : drop_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      used_q      <= '0;
      cnt_q       <= '0;
      drop_q      <= '0;
      rem_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      used_q      <= used_d;
      cnt_q       <= cnt_d;
      drop_q      <= drop_d;
      rem_q       <= rem_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers of the header in flight; no reset needed.
  always_ff @(posedge clk_i) begin
    rd_ptr_q  <= rd_ptr_d;
    evict_q   <= evict_d;
    len_q     <= len_d;
    hdr_len_q <= hdr_len_d;
    status_q  <= status_d;
    out_q     <= out_d;
  end

  // The byte count never passes the ring size.
  `LPMR_ASSERT_IMP(a_used_in_range, 1'b1, used_q <= USED_W'(RING_BYTES),
    "ring byte count exceeds ring size")
  // A pending payload always belongs to a held message.
  `LPMR_ASSERT_IMP(a_pending_has_msg, rem_q != '0, cnt_q != '0,
    "payload pending with no message held")
  // An empty ring holds no bytes.
  `LPMR_ASSERT_IMP(a_empty_no_bytes, cnt_q == '0, used_q == '0,
    "bytes in use with no message held")
  // A header always starts the admission check on the next cycle.
  `LPMR_ASSERT_NXT(a_header_checked, in_acc && (in_word_i.op == OP_HEADER),
    state_q == ST_CHECK, "accepted header did not enter the check")

endmodule

`default_nettype wire

// ===== rtl/lpmr_ring_mem.sv =====
// Byte ring storage: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module lpmr_ring_mem import lpmr_pkg::*; #(
  parameter int unsigned DEPTH  = RING_BYTES_DEF,
  parameter int unsigned ADDR_W = $clog2(RING_BYTES_DEF)
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [BYTE_W-1:0] wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic      [BYTE_W-1:0] rd_data_o
);

  logic [BYTE_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the length-prefixed message ring push block.
`timescale 1ns / 1ps

import lpmr_pkg::*;

typedef bit [$clog2(RING_BYTES_DEF)-1:0] ring_ptr_t;

// Mirrors the ring bookkeeping and holds the admission results still to come.
class ring_push_scoreboard;
  bit [7:0]    ring_mem [RING_BYTES_DEF];
  ring_ptr_t   head_ptr;
  ring_ptr_t   tail_ptr;
  int unsigned bytes_in_use;
  int unsigned held_msgs;
  int unsigned unfilled_bytes;
  bit [31:0]   drop_count;
  bit [MAX_LEN_W-1:0] max_len;
  bit [LIMIT_W-1:0]   msg_limit;
  bit                 drop_oldest;
  out_word_t   admission_q[$];
  int unsigned errors;
  int unsigned results_checked;
  int unsigned words_in;
  int unsigned most_evicted;
  int unsigned status_hits [5];

  function new();
    max_len     = MAX_LEN_RST;
    msg_limit   = LIMIT_RST;
    drop_oldest = DROP_RST;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    case (idx)
      CFG_MAX_BYTES: max_len = value[MAX_LEN_W-1:0];
      CFG_MSG_LIMIT: msg_limit = value[LIMIT_W-1:0];
      CFG_DROP_MODE: drop_oldest = value[0];
      default: ;
    endcase
  endfunction

  function void bump_drops();
    if (drop_count != '1) drop_count++;
  endfunction

  // Retires the message at the head; fails when its stored header is unusable.
  function bit evict_oldest();
    int unsigned stored_len;
    int unsigned span;
    int unsigned i;
    ring_ptr_t   rd;
    if (held_msgs == 0 || bytes_in_use < HDR_BYTES) return 1'b0;
    rd = head_ptr;
    stored_len = 0;
    for (i = 0; i < HDR_BYTES; i++) begin
      stored_len[8*i +: 8] = ring_mem[rd];
      rd++;
    end
    span = HDR_BYTES + stored_len;
    if (span > bytes_in_use) return 1'b0;
    head_ptr = head_ptr + ring_ptr_t'(span);
    bytes_in_use -= span;
    held_msgs--;
    bump_drops();
    return 1'b1;
  endfunction

  function void note_word(in_word_t w);
    out_word_t   want;
    status_e     st;
    int unsigned len;
    int unsigned need;
    int unsigned cap;
    int unsigned evicted;
    int unsigned i;
    words_in++;
    if (w.op == OP_DATA) begin
      if (unfilled_bytes != 0) begin
        ring_mem[tail_ptr] = w.payload_byte;
        tail_ptr++;
        unfilled_bytes--;
      end
      return;
    end
    // A new header closes an unfinished payload; the unfilled bytes stay reserved.
    tail_ptr = tail_ptr + ring_ptr_t'(unfilled_bytes);
    unfilled_bytes = 0;
    len = w.message_length;
    need = HDR_BYTES + len;
    cap = (msg_limit < MAX_MESSAGES_DEF) ? msg_limit : MAX_MESSAGES_DEF;
    evicted = 0;
    st = STAT_ACCEPTED;
    if (len == 0) begin
      st = STAT_EMPTY;
    end else if (len > max_len) begin
      st = STAT_OVER_MAX;
      bump_drops();
    end else if (need > RING_BYTES_DEF) begin
      st = STAT_OVER_RING;
      bump_drops();
    end else begin
      if (drop_oldest) begin
        while ((held_msgs >= cap || RING_BYTES_DEF - bytes_in_use < need) && held_msgs > 0) begin
          if (!evict_oldest()) break;
          evicted++;
        end
      end
      if (held_msgs >= cap || RING_BYTES_DEF - bytes_in_use < need) begin
        st = STAT_NO_ROOM;
        bump_drops();
      end else begin
        for (i = 0; i < HDR_BYTES; i++) begin
          ring_mem[tail_ptr] = len[8*i +: 8];
          tail_ptr++;
        end
        bytes_in_use += need;
        held_msgs++;
        unfilled_bytes = len;
      end
    end
    want.status        = st;
    want.evicted_now   = HELD_W'(evicted);
    want.dropped_total = drop_count;
    want.messages_held = HELD_W'(held_msgs);
    want.bytes_used    = USED_OUT_W'(bytes_in_use);
    admission_q.push_back(want);
    status_hits[st]++;
    if (evicted > most_evicted) most_evicted = evicted;
  endfunction

  task report(string what);
    errors++;
    if (errors <= 100) $display("mismatch at %0t ns: %s", $time, what);
  endtask

  task check_status_word(out_word_t got);
    out_word_t want;
    if (admission_q.size() == 0) begin
      report($sformatf("result word %h arrived with nothing outstanding", got));
      return;
    end
    want = admission_q.pop_front();
    results_checked++;
    if (got.status !== want.status)
      report($sformatf("status %0d, expected %0d", got.status, want.status));
    if (got.evicted_now !== want.evicted_now)
      report($sformatf("evicted_now %0d, expected %0d", got.evicted_now, want.evicted_now));
    if (got.dropped_total !== want.dropped_total)
      report($sformatf("dropped_total %0d, expected %0d",
                       got.dropped_total, want.dropped_total));
    if (got.messages_held !== want.messages_held)
      report($sformatf("messages_held %0d, expected %0d",
                       got.messages_held, want.messages_held));
    if (got.bytes_used !== want.bytes_used)
      report($sformatf("bytes_used %0d, expected %0d", got.bytes_used, want.bytes_used));
  endtask
endclass

module testbench;

  // Longest stretch without any handshake before the run is declared hung. The
  // slowest legal stretch is a long receiver hold plus a header that evicts
  // every stored message, so this leaves a wide margin.
  localparam int unsigned STALL_LIMIT  = 20000;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned RUN_WORDS    = 75;
  localparam int unsigned RAND_PHASES  = 6;
  // Index past the last register; the block must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum int unsigned {RX_STEADY, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_pattern_e;

  logic                  clk_i;
  logic                  rst_ni    = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_word_t              in_word   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_word;

  ring_push_scoreboard sb = new();

  bit          hold_req = 1'b0;
  bit          gaps_on = 1'b0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;

  length_prefixed_message_ring_push u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Both handshakes are sampled here at the clock edge, before any of this
  // edge's nonblocking updates land, so ordering within the step cannot matter.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid && in_ready) sb.note_word(in_word);
    if (rst_ni && out_valid && out_ready) sb.check_status_word(out_word);
  end

  // Hang detector: any cycle without a handshake on either side counts.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("hang: no word moved for %0d cycles", STALL_LIMIT);
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // Result side. The receiver switches between a few stall patterns in windows
  // of random length. On request it holds off for a long counted stretch so the
  // block backs up and has to stall its input.
  initial begin
    rx_pattern_e rx_mode;
    int unsigned rx_left;
    rx_mode = RX_STEADY;
    rx_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        if (rx_left == 0) begin
          rx_mode = rx_pattern_e'($urandom_range(0, 3));
          rx_left = $urandom_range(16, 96);
        end
        rx_left--;
        case (rx_mode)
          RX_STEADY: out_ready <= 1'b1;
          RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:   out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Offers one word and returns at the edge where it is taken. When gaps are
  // enabled, words go out in bursts of random length separated by idle cycles.
  task automatic send_word(input in_word_t w);
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      burst_left--;
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk_i); while (in_ready !== 1'b1);
  endtask

  // Header word; the unused byte field carries noise the block must ignore.
  task automatic send_header(input int unsigned len);
    in_word_t w;
    w.op             = OP_HEADER;
    w.message_length = LEN_W'(len);
    w.payload_byte   = BYTE_W'($urandom);
    send_word(w);
  endtask

  // Data word; the unused length field carries noise.
  task automatic send_data(input int unsigned value);
    in_word_t w;
    w.op             = OP_DATA;
    w.message_length = LEN_W'($urandom);
    w.payload_byte   = BYTE_W'(value);
    send_word(w);
  endtask

  // Stops offering, waits for every outstanding result, then gives trailing
  // data words time to land before anything touches the registers.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (sb.admission_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Writes all three registers and the spare index. Bits above each register's
  // width are filled with noise, since the block must mask them off.
  task automatic set_regs(input int unsigned max_v, input int unsigned limit_v,
                          input int unsigned drop_v);
    logic [CFG_IDX_W-1:0]  idx_list [4];
    logic [CFG_DATA_W-1:0] val_list [4];
    idx_list = '{CFG_MAX_BYTES, CFG_MSG_LIMIT, CFG_DROP_MODE, CFG_SPARE};
    val_list[0] = CFG_DATA_W'(max_v);
    val_list[1] = CFG_DATA_W'((($urandom & 32'h7) << LIMIT_W) | (limit_v & 32'h1FF));
    val_list[2] = CFG_DATA_W'(($urandom & 32'hFFE) | (drop_v & 32'h1));
    val_list[3] = CFG_DATA_W'($urandom);
    foreach (idx_list[k]) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= idx_list[k];
      cfg_wdata <= val_list[k];
      @(posedge clk_i);
      sb.write_reg(idx_list[k], val_list[k]);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned p;
    int unsigned counted;
    int unsigned kind;
    int unsigned len;
    int unsigned n;
    int unsigned phase_max   [RAND_PHASES];
    int unsigned phase_limit [RAND_PHASES];
    int unsigned phase_drop  [RAND_PHASES];

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, reset settings: stray data word, empty message, two
    // rejections over the size limit, a complete and an unfinished payload,
    // then fill the ring until a header finds no room.
    send_data(8'h5A);
    send_header(0);
    send_header(16'hFFFF);
    send_header(1025);
    send_header(1);
    send_data(8'hFF);
    send_header(3);
    send_data(8'h00);
    repeat (4) send_header(1024);
    settle();

    // Largest size limit: lengths past the ring are rejected as over ring size,
    // and the largest legal message forces every stored one out.
    set_regs(4095, 256, 1);
    send_header(4093);
    send_header(4095);
    send_header(4092);
    send_header(1);
    settle();

    // A message limit of zero empties the ring and still rejects, with and
    // without drop-oldest.
    set_regs(4095, 0, 1);
    send_header(7);
    settle();
    set_regs(4095, 0, 0);
    send_header(7);
    settle();

    // A limit of one evicts on count alone.
    set_regs(4095, 1, 1);
    send_header(2);
    send_data(8'h01);
    send_data(8'h80);
    send_header(2);
    settle();

    // A size limit of zero rejects every nonempty message; the data word after
    // the rejection has no message to go into.
    set_regs(0, 1, 1);
    send_header(1);
    send_header(0);
    send_data(8'hC3);
    settle();

    // Fill to the message cap with tiny messages (a limit above the cap is
    // clamped), overflow once, then evict all of them with one large header.
    gaps_on = 1'b1;
    set_regs(4095, 511, 0);
    repeat (MAX_MESSAGES_DEF) send_header(1);
    settle();
    set_regs(4095, 511, 1);
    send_header(4092);

    // Random phases under several settings. Most traffic is complete messages
    // with short payloads; the rest is large headers that only reserve space,
    // truncated payloads, stray data words and unconstrained lengths.
    phase_max   = '{4095, 48, 2047, 12, 0, 0};
    phase_limit = '{256, 6, 511, 1, 0, 0};
    phase_drop  = '{1, 1, 0, 1, 0, 0};
    for (p = 0; p < RAND_PHASES; p++) begin
      settle();
      if (p >= 4) begin
        phase_max[p]   = $urandom_range(0, 4095);
        phase_limit[p] = $urandom_range(0, 511);
        phase_drop[p]  = $urandom_range(0, 1);
      end
      set_regs(phase_max[p], phase_limit[p], phase_drop[p]);
      // One phase runs back to back; the first one starts under a long hold.
      gaps_on = (p != 2);
      if (p == 0) hold_req = 1'b1;
      counted = 0;
      while (counted < RUN_WORDS) begin
        kind = $urandom_range(0, 99);
        if (kind < 55) begin
          len = $urandom_range(0, 12);
          send_header(len);
          repeat (len) send_data($urandom);
          counted += len + 1;
        end else if (kind < 75) begin
          len = $urandom_range(0, 1) ? $urandom_range(1, 4095)
                                     : $urandom_range(1, sb.max_len + 1);
          send_header(len);
          counted++;
        end else if (kind < 88) begin
          len = $urandom_range(2, 20);
          n = $urandom_range(0, len - 1);
          send_header(len);
          repeat (n) send_data($urandom);
          counted += n + 1;
        end else if (kind < 94) begin
          repeat ($urandom_range(1, 3)) send_data($urandom);
        end else begin
          send_header($urandom_range(0, 65535));
          counted++;
        end
      end
    end

    settle();
    $display("Run covered %0d words in, %0d results: %0d accepted, %0d empty, %0d over max,",
             sb.words_in, sb.results_checked, sb.status_hits[STAT_ACCEPTED],
             sb.status_hits[STAT_EMPTY], sb.status_hits[STAT_OVER_MAX]);
    $display("%0d over ring, %0d no room; most evicted by one header %0d, drops %0d.",
             sb.status_hits[STAT_OVER_RING], sb.status_hits[STAT_NO_ROOM],
             sb.most_evicted, sb.drop_count);
    if (sb.errors == 0 && sb.admission_q.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lpmr_pkg.sv
rtl/lpmr_ring_mem.sv
rtl/length_prefixed_message_ring_push.sv
tb/testbench.sv
